/* src/eip_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eip_pkg
// Shared constants, codes and types of the Ethernet/IPv4/L4 header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package eip_pkg;

  localparam int unsigned IDX_W = 16;

  // Bytes beyond this count in one frame are ignored.
  localparam logic [IDX_W-1:0] MAX_FRAME_BYTES = 16'd65535;

  localparam logic [IDX_W-1:0] ETH_HDR_BYTES  = 16'd14;
  localparam logic [15:0]      ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [IDX_W-1:0] IP_MIN_HDR     = 16'd20;
  localparam logic [IDX_W-1:0] TCP_MIN_HDR    = 16'd20;
  localparam logic [IDX_W-1:0] UDP_HDR        = 16'd8;
  localparam logic [7:0]       PROTO_TCP      = 8'd6;
  localparam logic [7:0]       PROTO_UDP      = 8'd17;
  localparam logic [3:0]       IP_VERSION_4   = 4'd4;

  // Frame byte positions of the captured header fields.
  localparam logic [IDX_W-1:0] POS_ETYPE_HI  = 16'd12;
  localparam logic [IDX_W-1:0] POS_ETYPE_LO  = 16'd13;
  localparam logic [IDX_W-1:0] POS_VER_LEN   = 16'd14;
  localparam logic [IDX_W-1:0] POS_TLEN_HI   = 16'd16;
  localparam logic [IDX_W-1:0] POS_TLEN_LO   = 16'd17;
  localparam logic [IDX_W-1:0] POS_PROTOCOL  = 16'd23;
  localparam logic [IDX_W-1:0] POS_SRC_FIRST = 16'd26;
  localparam logic [IDX_W-1:0] POS_SRC_LAST  = 16'd29;
  localparam logic [IDX_W-1:0] POS_DST_FIRST = 16'd30;
  localparam logic [IDX_W-1:0] POS_DST_LAST  = 16'd33;
  localparam logic [IDX_W-1:0] L4_PORT_BYTES = 16'd4;
  localparam logic [IDX_W-1:0] L4_TCP_DOFF   = 16'd12;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_SHORT_ETH = 3'd1;
  localparam logic [2:0] STATUS_NOT_IPV4  = 3'd2;
  localparam logic [2:0] STATUS_BAD_IP    = 3'd3;
  localparam logic [2:0] STATUS_OTHER     = 3'd4;
  localparam logic [2:0] STATUS_BAD_L4    = 3'd5;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TCP  = 2'd1;
  localparam logic [1:0] KIND_UDP  = 2'd2;

  // Header fields of one complete frame, as captured at its last byte.
  typedef struct packed {
    logic [IDX_W-1:0] frame_len;
    logic [15:0]      ether_kind;
    logic [7:0]       ip_ver_len;
    logic [15:0]      ip_total_len;
    logic [7:0]       ip_protocol;
    logic [31:0]      src_addr;
    logic [31:0]      dst_addr;
    logic [31:0]      port_pair;
    logic [7:0]       tcp_offset_byte;
  } frame_info_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  l4_kind;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
  } parse_result_t;

endpackage

`default_nettype wire

/* src/eip_field_capture.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eip_field_capture
// Tracks the byte position in the frame, captures the header fields and
// holds a snapshot of them once the last byte of a frame has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module eip_field_capture (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 take,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 last_byte,
  input  wire logic                 snap_pop,
  output logic                      snap_valid,
  output eip_pkg::frame_info_t      snap
);
  import eip_pkg::*;

  frame_info_t      st_r, st_nxt, upd;
  frame_info_t      snap_r, snap_nxt;
  logic             snap_valid_r, snap_valid_nxt;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] l4_start;
  logic [IDX_W-1:0] l4_rel;
  logic             taking;
  logic             frame_end;

  assign idx      = st_r.frame_len;
  assign taking   = take && (idx < MAX_FRAME_BYTES);
  assign frame_end = take && last_byte;
  // Transport byte positions follow the header length as it stands now.
  assign l4_start = ETH_HDR_BYTES + {10'd0, st_r.ip_ver_len[3:0], 2'b00};
  assign l4_rel   = idx - l4_start;

  always_comb begin
    upd = st_r;
    if (taking) begin
      upd.frame_len = idx + 16'd1;
      if (idx == POS_ETYPE_HI || idx == POS_ETYPE_LO) begin
        upd.ether_kind = {st_r.ether_kind[7:0], data_byte};
      end else if (idx == POS_VER_LEN) begin
        upd.ip_ver_len = data_byte;
      end else if (idx == POS_TLEN_HI || idx == POS_TLEN_LO) begin
        upd.ip_total_len = {st_r.ip_total_len[7:0], data_byte};
      end else if (idx == POS_PROTOCOL) begin
        upd.ip_protocol = data_byte;
      end else if (idx >= POS_SRC_FIRST && idx <= POS_SRC_LAST) begin
        upd.src_addr = {st_r.src_addr[23:0], data_byte};
      end else if (idx >= POS_DST_FIRST && idx <= POS_DST_LAST) begin
        upd.dst_addr = {st_r.dst_addr[23:0], data_byte};
      end
      if (idx > POS_VER_LEN && idx >= l4_start) begin
        if (l4_rel < L4_PORT_BYTES) begin
          case (l4_rel[1:0])
            2'd0:    upd.port_pair[31:24] = data_byte;
            2'd1:    upd.port_pair[23:16] = data_byte;
            2'd2:    upd.port_pair[15:8]  = data_byte;
            default: upd.port_pair[7:0]   = data_byte;
          endcase
        end else if (l4_rel == L4_TCP_DOFF) begin
          upd.tcp_offset_byte = data_byte;
        end
      end
    end
  end

  always_comb begin
    st_nxt         = frame_end ? '0 : upd;
    snap_nxt       = frame_end ? upd : snap_r;
    snap_valid_nxt = frame_end ? 1'b1 : (snap_pop ? 1'b0 : snap_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      snap_valid_r <= snap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

`default_nettype wire

/* src/eip_result_calc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eip_result_calc
// Checks the captured header fields of one frame and works out the status,
// transport kind, ports and payload position.
// ----------------------------------------------------------------------------
`default_nettype none

module eip_result_calc (
  input  wire eip_pkg::frame_info_t info,
  output eip_pkg::parse_result_t    res
);
  import eip_pkg::*;

  logic [IDX_W-1:0] rem;
  logic [IDX_W-1:0] ihl;
  logic [IDX_W-1:0] span;
  logic [IDX_W-1:0] l4_room;
  logic [IDX_W-1:0] l4_start;
  logic [IDX_W-1:0] doff;
  logic             ip_bad;

  always_comb begin
    rem      = info.frame_len - ETH_HDR_BYTES;
    ihl      = {10'd0, info.ip_ver_len[3:0], 2'b00};
    doff     = {10'd0, info.tcp_offset_byte[7:4], 2'b00};
    // The total length limits the span only when it is set and fits the capture.
    span     = (info.ip_total_len != 16'd0 && info.ip_total_len <= rem) ?
               info.ip_total_len : rem;
    l4_room  = span - ihl;
    l4_start = ETH_HDR_BYTES + ihl;
    ip_bad   = (rem < IP_MIN_HDR) || (info.ip_ver_len[7:4] != IP_VERSION_4) ||
               (ihl < IP_MIN_HDR) || (ihl > rem);

    res = '0;
    if (info.frame_len < ETH_HDR_BYTES) begin
      res.status = STATUS_SHORT_ETH;
    end else if (info.ether_kind != ETHERTYPE_IPV4) begin
      res.status = STATUS_NOT_IPV4;
    end else if (ip_bad) begin
      res.status = STATUS_BAD_IP;
    end else begin
      res.src_addr = info.src_addr;
      res.dst_addr = info.dst_addr;
      if (ihl > span) begin
        res.status = STATUS_BAD_IP;
      end else if (info.ip_protocol == PROTO_TCP) begin
        if (l4_room < TCP_MIN_HDR) begin
          res.status = STATUS_BAD_L4;
        end else begin
          res.l4_kind  = KIND_TCP;
          res.l4_sport = info.port_pair[31:16];
          res.l4_dport = info.port_pair[15:0];
          if (doff < TCP_MIN_HDR || doff > l4_room) begin
            res.status = STATUS_BAD_L4;
          end else begin
            res.payload_offset = l4_start + doff;
            res.payload_length = l4_room - doff;
          end
        end
      end else if (info.ip_protocol == PROTO_UDP) begin
        if (l4_room < UDP_HDR) begin
          res.status = STATUS_BAD_L4;
        end else begin
          res.l4_kind        = KIND_UDP;
          res.l4_sport       = info.port_pair[31:16];
          res.l4_dport       = info.port_pair[15:0];
          res.payload_offset = l4_start + UDP_HDR;
          res.payload_length = l4_room - UDP_HDR;
        end
      end else begin
        res.status = STATUS_OTHER;
      end
    end
  end

endmodule

`default_nettype wire

/* src/eth_ipv4_l4_header_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eth_ipv4_l4_header_parser
// Streams a captured Ethernet frame byte by byte and reports the IPv4 and
// TCP/UDP header summary of the frame once its last byte is accepted.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one frame byte per request,
// with in_last_byte set on the final byte of each frame. The result channel
// (out_valid/out_ready) carries one request per frame: status, transport
// kind, addresses, ports and the payload offset and length.
// Throughput is one byte per cycle while in_ready stays high. The result of a
// frame passes through the frame snapshot register and then the result
// register after its last byte is accepted.
// Bytes beyond 65535 in one frame are ignored.
// Synchronous active-low reset clears the byte counter, the captured fields
// and both valid flags; the next accepted byte starts a new frame.
// When the receiver stalls, the result register holds its request and bytes
// keep flowing until a second finished frame waits in the snapshot register;
// in_ready then drops until the result register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module eth_ipv4_l4_header_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [1:0]       out_l4_kind,
  output logic [31:0]      out_src_addr,
  output logic [31:0]      out_dst_addr,
  output logic [15:0]      out_src_port_out,
  output logic [15:0]      out_dst_port_out,
  output logic [15:0]      out_payload_offset,
  output logic [15:0]      out_payload_length
);
  import eip_pkg::*;

  frame_info_t   snap;
  parse_result_t calc_res;
  parse_result_t res_r, res_nxt;
  logic          snap_valid;
  logic          snap_pop;
  logic          take;
  logic          out_valid_r, out_valid_nxt;

  assign snap_pop = snap_valid && (!out_valid_r || out_ready);
  assign in_ready = !snap_valid || snap_pop;
  assign take     = in_valid && in_ready;

  eip_field_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .data_byte  (in_data_byte),
    .last_byte  (in_last_byte),
    .snap_pop   (snap_pop),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  eip_result_calc u_calc (
    .info (snap),
    .res  (calc_res)
  );

  always_comb begin
    res_nxt       = snap_pop ? calc_res : res_r;
    out_valid_nxt = snap_pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_l4_kind        = res_r.l4_kind;
  assign out_src_addr       = res_r.src_addr;
  assign out_dst_addr       = res_r.dst_addr;
  assign out_src_port_out   = res_r.l4_sport;
  assign out_dst_port_out   = res_r.l4_dport;
  assign out_payload_offset = res_r.payload_offset;
  assign out_payload_length = res_r.payload_length;

`ifndef NO_ASSERTIONS
  // A last byte always lands in the snapshot register.
  a_last_snapped: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_last_byte |=> snap_valid)
    else $error("last byte accepted without a frame snapshot");

  // Payload position is reported only for frames that parse cleanly.
  a_payload_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |->
      out_payload_offset == 16'd0 && out_payload_length == 16'd0)
    else $error("payload position given for a failed frame");

  // Without a transport kind there are no ports.
  a_ports_need_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_l4_kind == KIND_NONE |->
      out_src_port_out == 16'd0 && out_dst_port_out == 16'd0)
    else $error("ports reported without a transport kind");

  // A clean frame always names its transport.
  a_ok_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_OK |-> out_l4_kind != KIND_NONE)
    else $error("ok status without a transport kind");

  // A stalled result is never overwritten by the next snapshot.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !snap_pop)
    else $error("snapshot moved into a stalled result register");
`endif

endmodule

`default_nettype wire

/* dv/eth_ipv4_l4_header_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eth_ipv4_l4_header_parser_tb
// Streams whole Ethernet frames into the parser one byte per request and
// checks each frame summary against a byte-level parser model kept here.
// It starts with directed frames for every status and special case, then
// sends random frames, most of them well formed. Both sides idle at random.
// ----------------------------------------------------------------------------

module eth_ipv4_l4_header_parser_tb;
  import eip_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned MAX_PRINTED    = 50;
  localparam int unsigned RANDOM_BYTES   = 150;
  localparam int unsigned RANDOM_FRAMES  = 3;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned gap;
    bit          hold;
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [1:0]  out_l4_kind;
  logic [31:0] out_src_addr;
  logic [31:0] out_dst_addr;
  logic [15:0] out_src_port_out;
  logic [15:0] out_dst_port_out;
  logic [15:0] out_payload_offset;
  logic [15:0] out_payload_length;

  eth_ipv4_l4_header_parser uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_l4_kind        (out_l4_kind),
    .out_src_addr       (out_src_addr),
    .out_dst_addr       (out_dst_addr),
    .out_src_port_out   (out_src_port_out),
    .out_dst_port_out   (out_dst_port_out),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length)
  );

  always #5 clk = ~clk;

  byte_item_t    pending_bytes[$];
  logic [7:0]    frame_buf[$];
  parse_result_t expected_summaries[$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned frames_queued = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned status_tally[8];

  // Header fields of the frame in flight, as the parser sees them.
  int unsigned frame_len = 0;
  logic [15:0] cap_etype = '0;
  logic [7:0]  cap_ver_len = '0;
  logic [15:0] cap_total_len = '0;
  logic [7:0]  cap_protocol = '0;
  logic [31:0] cap_src = '0;
  logic [31:0] cap_dst = '0;
  logic [31:0] cap_ports = '0;
  logic [7:0]  cap_doff = '0;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Takes one frame byte; on the last byte it returns 1 with the summary.
  function automatic bit parse_frame_byte(input logic [7:0] b, input logic last,
                                          output parse_result_t res);
    int unsigned l4s, rel, rem, ihl, span, l4r, doff;
    res = '0;
    res.status = STATUS_OK;
    res.l4_kind = KIND_NONE;
    if (frame_len < MAX_FRAME_BYTES) begin
      // Transport positions follow the header length as it stands right now.
      l4s = ETH_HDR_BYTES + int'(cap_ver_len[3:0]) * 4;
      if (frame_len == POS_ETYPE_HI || frame_len == POS_ETYPE_LO) begin
        cap_etype = {cap_etype[7:0], b};
      end else if (frame_len == POS_VER_LEN) begin
        cap_ver_len = b;
      end else if (frame_len == POS_TLEN_HI || frame_len == POS_TLEN_LO) begin
        cap_total_len = {cap_total_len[7:0], b};
      end else if (frame_len == POS_PROTOCOL) begin
        cap_protocol = b;
      end else if (frame_len >= POS_SRC_FIRST && frame_len <= POS_SRC_LAST) begin
        cap_src = {cap_src[23:0], b};
      end else if (frame_len >= POS_DST_FIRST && frame_len <= POS_DST_LAST) begin
        cap_dst = {cap_dst[23:0], b};
      end
      if (frame_len > POS_VER_LEN && frame_len >= l4s) begin
        rel = frame_len - l4s;
        if (rel < L4_PORT_BYTES) begin
          cap_ports[(3 - rel) * 8 +: 8] = b;
        end else if (rel == L4_TCP_DOFF) begin
          cap_doff = b;
        end
      end
      frame_len++;
    end
    if (!last) return 1'b0;

    if (frame_len < ETH_HDR_BYTES) begin
      res.status = STATUS_SHORT_ETH;
    end else if (cap_etype != ETHERTYPE_IPV4) begin
      res.status = STATUS_NOT_IPV4;
    end else begin
      rem = frame_len - ETH_HDR_BYTES;
      ihl = int'(cap_ver_len[3:0]) * 4;
      if (rem < IP_MIN_HDR || cap_ver_len[7:4] != IP_VERSION_4 ||
          ihl < IP_MIN_HDR || ihl > rem) begin
        res.status = STATUS_BAD_IP;
      end else begin
        span = (cap_total_len != 0 && cap_total_len <= rem) ? cap_total_len : rem;
        res.src_addr = cap_src;
        res.dst_addr = cap_dst;
        if (ihl > span) begin
          res.status = STATUS_BAD_IP;
        end else begin
          l4r = span - ihl;
          l4s = ETH_HDR_BYTES + ihl;
          if (cap_protocol == PROTO_TCP) begin
            if (l4r < TCP_MIN_HDR) begin
              res.status = STATUS_BAD_L4;
            end else begin
              doff = int'(cap_doff[7:4]) * 4;
              res.l4_kind = KIND_TCP;
              res.l4_sport = cap_ports[31:16];
              res.l4_dport = cap_ports[15:0];
              if (doff < TCP_MIN_HDR || doff > l4r) begin
                res.status = STATUS_BAD_L4;
              end else begin
                res.payload_offset = 16'(l4s + doff);
                res.payload_length = 16'(l4r - doff);
              end
            end
          end else if (cap_protocol == PROTO_UDP) begin
            if (l4r < UDP_HDR) begin
              res.status = STATUS_BAD_L4;
            end else begin
              res.l4_kind = KIND_UDP;
              res.l4_sport = cap_ports[31:16];
              res.l4_dport = cap_ports[15:0];
              res.payload_offset = 16'(l4s + UDP_HDR);
              res.payload_length = 16'(l4r - UDP_HDR);
            end
          end else begin
            res.status = STATUS_OTHER;
          end
        end
      end
    end

    frame_len = 0;
    cap_etype = '0;
    cap_ver_len = '0;
    cap_total_len = '0;
    cap_protocol = '0;
    cap_src = '0;
    cap_dst = '0;
    cap_ports = '0;
    cap_doff = '0;
    return 1'b1;
  endfunction

  // Fills frame_buf with random bytes and lays the given header fields over
  // them, as far as the frame reaches.
  task automatic build_frame(input logic [15:0] etype, input logic [7:0] ver_len,
                             input logic [15:0] tot_len, input logic [7:0] proto,
                             input logic [7:0] doff_byte, input int unsigned len);
    int unsigned doff_pos;
    doff_pos = ETH_HDR_BYTES + int'(ver_len[3:0]) * 4 + L4_TCP_DOFF;
    frame_buf.delete();
    for (int unsigned i = 0; i < len; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
    if (len > POS_ETYPE_HI) frame_buf[POS_ETYPE_HI] = etype[15:8];
    if (len > POS_ETYPE_LO) frame_buf[POS_ETYPE_LO] = etype[7:0];
    if (len > POS_VER_LEN)  frame_buf[POS_VER_LEN]  = ver_len;
    if (len > POS_TLEN_HI)  frame_buf[POS_TLEN_HI]  = tot_len[15:8];
    if (len > POS_TLEN_LO)  frame_buf[POS_TLEN_LO]  = tot_len[7:0];
    if (len > POS_PROTOCOL) frame_buf[POS_PROTOCOL] = proto;
    if (len > doff_pos)     frame_buf[doff_pos]     = doff_byte;
  endtask

  task automatic queue_frame(input bit calm, input bit hold);
    byte_item_t item;
    foreach (frame_buf[i]) begin
      item.data = frame_buf[i];
      item.last = (i == frame_buf.size() - 1);
      item.gap  = calm ? 0 : $urandom_range(0, 4);
      item.hold = hold && (i == 0);
      pending_bytes.push_back(item);
    end
    frames_queued++;
    bytes_queued += frame_buf.size();
  endtask

  // Byte driver: a held item waits for every pending summary to come back.
  always @(posedge clk) begin : drive_proc
    bit            offering;
    int unsigned   gap_count;
    byte_item_t    nxt;
    parse_result_t summary;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_count = 0;
    end else begin
      offering = in_valid;
      if (in_valid && in_ready) begin
        if (parse_frame_byte(in_data_byte, in_last_byte, summary)) begin
          expected_summaries.push_back(summary);
        end
        bytes_taken++;
        offering = 1'b0;
      end
      if (!offering && pending_bytes.size() != 0) begin
        nxt = pending_bytes[0];
        if (nxt.hold && expected_summaries.size() != 0) begin
          gap_count = 0;
        end else if (gap_count < nxt.gap) begin
          gap_count++;
        end else begin
          void'(pending_bytes.pop_front());
          in_data_byte <= nxt.data;
          in_last_byte <= nxt.last;
          offering = 1'b1;
          gap_count = 0;
        end
      end
      in_valid <= offering;
    end
  end

  // Result monitor with random receiver stalls and stall-free stretches.
  always @(posedge clk) begin : watch_proc
    int unsigned   stall_left;
    parse_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_summaries.size() == 0) begin
          report_mismatch("frame summary arrived with no frame pending");
        end else begin
          want = expected_summaries.pop_front();
          status_tally[want.status]++;
          check_field("status", out_status, want.status);
          check_field("l4_kind", out_l4_kind, want.l4_kind);
          check_field("src_addr", out_src_addr, want.src_addr);
          check_field("dst_addr", out_dst_addr, want.dst_addr);
          check_field("src_port_out", out_src_port_out, want.l4_sport);
          check_field("dst_port_out", out_dst_port_out, want.l4_dport);
          check_field("payload_offset", out_payload_offset, want.payload_offset);
          check_field("payload_length", out_payload_length, want.payload_length);
        end
        stall_left = ((results_seen / 40) % 4 == 3) ? 0 : $urandom_range(0, 4);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d frame summaries still pending",
               cycle_count, expected_summaries.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus_proc
    int unsigned ihl_w, doff_w, hdr, len, random_start, random_frames;
    logic [15:0] tot;
    logic [7:0]  vl, pr;
    bit          calm;

    // Directed frames: each status and each special case.
    build_frame(ETHERTYPE_IPV4, 8'h45, 16'd0, PROTO_TCP, 8'h50, 1);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'h45, 16'd0, PROTO_TCP, 8'h50, 13);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'h45, 16'd0, PROTO_TCP, 8'h50, 14);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV6, 8'h45, 16'd0, PROTO_TCP, 8'h50, 60);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'h65, 16'd0, PROTO_UDP, 8'h50, 60);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'hF5, 16'd0, PROTO_UDP, 8'h50, 60);
    queue_frame(1'b0, 1'b0);
    // Header lengths below the minimum or past the end of the frame move the transport capture window.
    build_frame(ETHERTYPE_IPV4, 8'h44, 16'd0, PROTO_TCP, 8'h50, 60);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'h40, 16'd0, PROTO_TCP, 8'h50, 60);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'h4F, 16'd0, PROTO_UDP, 8'h50, 54);
    queue_frame(1'b0, 1'b0);
    // Header fits the frame but not the clamped total length.
    build_frame(ETHERTYPE_IPV4, 8'h46, 16'd22, PROTO_UDP, 8'h50, 60);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'h45, 16'd0, PROTO_UDP, 8'h50, 50);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'h45, 16'd30, PROTO_UDP, 8'h50, 70);
    queue_frame(1'b0, 1'b1);
    build_frame(ETHERTYPE_IPV4, 8'h45, 16'd0, PROTO_UDP, 8'h50, 41);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'h45, 16'd0, PROTO_UDP, 8'h50, 42);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'h45, 16'd0, PROTO_TCP, 8'h50, 59);
    queue_frame(1'b1, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'h45, 16'd0, PROTO_TCP, 8'hF0, 97);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'h45, 16'd0, PROTO_TCP, 8'h40, 70);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'h45, 16'd0, PROTO_TCP, 8'h80, 58);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'h45, 16'd0, PROTO_TCP, 8'h50, 53);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'h45, 16'd0, PROTO_ICMP, 8'h50, 60);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'h45, 16'hFFFF, PROTO_UDP, 8'h50, 60);
    queue_frame(1'b0, 1'b0);
    build_frame(ETHERTYPE_IPV4, 8'h4F, 16'd0, PROTO_UDP, 8'h50, 86);
    queue_frame(1'b0, 1'b0);

    // Random frames: mostly well formed with random content, some noise.
    random_start = bytes_queued;
    random_frames = 0;
    calm = 1'b0;
    while (bytes_queued - random_start < RANDOM_BYTES || random_frames < RANDOM_FRAMES) begin
      if ($urandom_range(0, 5) == 0) calm = !calm;
      if ($urandom_range(0, 3) != 0) begin
        ihl_w = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
        vl = {IP_VERSION_4, 4'(ihl_w)};
        if ($urandom_range(0, 15) == 0) vl[7:4] = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
          0, 1, 2, 3: pr = PROTO_TCP;
          4, 5, 6, 7: pr = PROTO_UDP;
          8:          pr = PROTO_ICMP;
          default:    pr = 8'($urandom_range(0, 255));
        endcase
        doff_w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 8);
        hdr = (pr == PROTO_TCP) ? ((doff_w < 5) ? 20 : doff_w * 4) : UDP_HDR;
        len = ETH_HDR_BYTES + ihl_w * 4 + hdr + $urandom_range(0, 20);
        if ($urandom_range(0, 7) == 0) len = len - $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0:       tot = 16'd0;
          1:       tot = 16'(len - ETH_HDR_BYTES);
          2:       tot = 16'(len - ETH_HDR_BYTES - $urandom_range(0, 10));
          default: tot = 16'($urandom_range(0, 65535));
        endcase
        build_frame(ETHERTYPE_IPV4, vl, tot, pr,
                    {4'(doff_w), 4'($urandom_range(0, 15))}, len);
      end else begin
        build_frame(($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535)) : ETHERTYPE_IPV4,
                    8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    $urandom_range(1, 70));
      end
      queue_frame(calm, $urandom_range(0, 19) == 0);
      random_frames++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken != bytes_queued) @(posedge clk);
    while (expected_summaries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    while (expected_summaries.size() != 0) begin
      void'(expected_summaries.pop_front());
      report_mismatch("frame summary never arrived");
    end

    $display("Sent %0d frames (%0d bytes), checked %0d summaries in %0d cycles.",
             frames_queued, bytes_taken, results_seen, cycle_count);
    $display("Statuses: ok %0d, short %0d, not IPv4 %0d, bad IP %0d, other %0d, bad L4 %0d",
             status_tally[STATUS_OK], status_tally[STATUS_SHORT_ETH],
             status_tally[STATUS_NOT_IPV4], status_tally[STATUS_BAD_IP],
             status_tally[STATUS_OTHER], status_tally[STATUS_BAD_L4]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/eip_pkg.sv
src/eip_field_capture.sv
src/eip_result_calc.sv
src/eth_ipv4_l4_header_parser.sv
dv/eth_ipv4_l4_header_parser_tb.sv
